FILE: src/vgaac_pkg.sv
// Package for the VGA attribute controller: item, result and config types,
// request codes, register indexes and configuration addresses.
// No dependencies.
`default_nettype none
package vgaac_pkg;

	typedef enum logic [1:0] {
		REQ_WRITE      = 2'd0,
		REQ_READ_INDEX = 2'd1,
		REQ_READ_DATA  = 2'd2,
		REQ_TRANSLATE  = 2'd3
	} req_type_t;

	localparam int PALETTE_ENTRIES = 16;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

	localparam logic [1:0] VMODE_TEXT = 2'd0;
	localparam logic [1:0] VMODE_256  = 2'd1;

	localparam logic [4:0] IDX_MODE_CTRL = 5'h10;
	localparam logic [4:0] IDX_OVERSCAN  = 5'h11;
	localparam logic [4:0] IDX_PLANE_EN  = 5'h12;
	localparam logic [4:0] IDX_PAN       = 5'h13;
	localparam logic [4:0] IDX_COLOR_SEL = 5'h14;

	localparam logic [1:0] CFG_IS_VGA     = 2'd0;
	localparam logic [1:0] CFG_REMAP_LOW4 = 2'd1;
	localparam logic [1:0] CFG_VIDEO_MODE = 2'd2;

	typedef struct packed {
		logic       is_vga;
		logic       remap_low4;
		logic [1:0] video_mode;
	} cfg_t;

	typedef struct packed {
		req_type_t  req_type;
		logic [7:0] write_value;
		logic [3:0] pixel_attr;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] dac_index;
		logic [3:0] pel_shift;
	} res_t;

endpackage
`default_nettype wire

FILE: src/vga_attribute_controller_unit.sv
// Top level of the VGA attribute controller: stream ports, input and result
// registers, APB configuration registers. Depends on vgaac_pkg and vgaac_core.
`default_nettype none
// Each accepted word yields one result word. A new word can be taken every
// cycle unless the output stalls; a word passes through the input register
// and then the result register. Register state is updated as the word moves
// from the input register to the result register, so words act in order. A
// full result register that is not taken holds both stages.
module vga_attribute_controller_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,   // write_value[7:0], pixel_attr[11:8], zero[15:12]
	input  wire [1:0]  s_tuser,   // req_type[1:0]
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [23:0] m_tdata,  // read_data[7:0], dac_index[15:8], pel_shift[19:16], zero
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [3:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import vgaac_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_s2;
	logic  valid_s2;
	res_t  core_res;
	logic  advance;
	logic  step;

	assign pready   = 1'b1;
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.pel_shift, res_s2.dac_index, res_s2.read_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_vga     <= 1'b1;
			cfg_q.remap_low4 <= 1'b0;
			cfg_q.video_mode <= VMODE_TEXT;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				CFG_IS_VGA:     cfg_q.is_vga     <= pwdata[0];
				CFG_REMAP_LOW4: cfg_q.remap_low4 <= pwdata[0];
				CFG_VIDEO_MODE: cfg_q.video_mode <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			CFG_IS_VGA:     prdata = {31'd0, cfg_q.is_vga};
			CFG_REMAP_LOW4: prdata = {31'd0, cfg_q.remap_low4};
			CFG_VIDEO_MODE: prdata = {30'd0, cfg_q.video_mode};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type    <= req_type_t'(s_tuser);
			item_s1.write_value <= s_tdata[7:0];
			item_s1.pixel_attr  <= s_tdata[11:8];
		end
		if (step)
			res_s2 <= core_res;
	end

	vgaac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (step),
		.item   (item_s1),
		.res    (core_res)
	);

`ifndef SYNTHESIS
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:16] <= 4'd8))
		else $error("pel_shift above 8");
	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid)
		else $error("result lost after step");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");
	a_idle_dac: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.req_type != REQ_TRANSLATE) |=> (m_tdata[15:8] == 8'd0))
		else $error("dac_index set on non-translate word");
`endif

endmodule
`default_nettype wire

FILE: src/vgaac_core.sv
// Attribute controller state: index/data flip-flop, palette, mode, overscan,
// plane enable, panning and color select registers, with the per-word result logic.
// Depends on vgaac_pkg.
`default_nettype none
module vgaac_core (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire vgaac_pkg::cfg_t     cfg,
	input  wire                      step,
	input  wire vgaac_pkg::item_t    item,
	output vgaac_pkg::res_t          res
);
	import vgaac_pkg::*;

	logic             data_phase_q, data_phase_d;
	logic [4:0]       reg_index_q, reg_index_d;
	logic             pal_access_q, pal_access_d;
	logic [5:0]       palette_q [PALETTE_ENTRIES];
	logic [7:0]       mode_ctrl_q, mode_ctrl_d;
	logic [7:0]       border_q, border_d;
	logic [7:0]       plane_en_q, plane_en_d;
	logic [3:0]       pan_q, pan_d;
	logic [7:0]       color_sel_q, color_sel_d;
	logic [3:0]       shift_q, shift_d;

	logic             pal_we;
	logic [PAL_AW-1:0] pal_ra;
	logic [5:0]       pal_rd;
	logic [7:0]       mc_new;
	logic [7:0]       dac_v;
	logic [7:0]       rd;
	logic [7:0]       dac;

	function automatic logic [3:0] text_shift(input logic [7:0] v, input logic nine_dot);
		logic [3:0] r;
		if (v[7:3] != 5'd0)
			r = 4'd0;
		else if (nine_dot)
			r = v[3:0] + 4'd1;
		else
			r = v[3:0];
		return r;
	endfunction

	assign pal_ra = (item.req_type == REQ_TRANSLATE) ?
		(item.pixel_attr[PAL_AW-1:0] & plane_en_q[PAL_AW-1:0]) : reg_index_q[PAL_AW-1:0];
	assign pal_rd = palette_q[pal_ra];
	assign mc_new = cfg.is_vga ? item.write_value : {3'b000, item.write_value[4:0]};

	always_comb begin
		data_phase_d = data_phase_q;
		reg_index_d  = reg_index_q;
		pal_access_d = pal_access_q;
		mode_ctrl_d  = mode_ctrl_q;
		border_d     = border_q;
		plane_en_d   = plane_en_q;
		pan_d        = pan_q;
		color_sel_d  = color_sel_q;
		shift_d      = shift_q;
		pal_we       = 1'b0;
		rd           = 8'd0;
		dac          = 8'd0;
		dac_v        = {2'b00, pal_rd};
		case (item.req_type)
			REQ_WRITE: begin
				if (!data_phase_q) begin
					reg_index_d  = item.write_value[4:0];
					pal_access_d = ~item.write_value[5];
					data_phase_d = 1'b1;
				end else begin
					data_phase_d = 1'b0;
					if (!reg_index_q[4]) begin
						pal_we = pal_access_q;
					end else begin
						case (reg_index_q)
							IDX_MODE_CTRL: begin
								mode_ctrl_d = mc_new;
								if ((mc_new[2] ^ mode_ctrl_q[2]) && cfg.video_mode == VMODE_TEXT)
									shift_d = text_shift({4'd0, pan_q}, mc_new[2]);
							end
							IDX_OVERSCAN: border_d   = item.write_value;
							IDX_PLANE_EN: plane_en_d = item.write_value;
							IDX_PAN: begin
								pan_d = item.write_value[3:0];
								case (cfg.video_mode)
									VMODE_TEXT: shift_d = text_shift(item.write_value, mode_ctrl_q[2]);
									VMODE_256:  shift_d = {2'b00, item.write_value[2:1]};
									default:    shift_d = {1'b0, item.write_value[2:0]};
								endcase
							end
							IDX_COLOR_SEL: color_sel_d = cfg.is_vga ? item.write_value : 8'd0;
							default: ;
						endcase
					end
				end
			end
			REQ_READ_INDEX: rd = {2'b00, ~pal_access_q, reg_index_q};
			REQ_READ_DATA: begin
				if (!reg_index_q[4]) begin
					rd = {2'b00, pal_rd};
				end else begin
					case (reg_index_q)
						IDX_MODE_CTRL: rd = mode_ctrl_q;
						IDX_OVERSCAN:  rd = border_q;
						IDX_PLANE_EN:  rd = plane_en_q;
						IDX_PAN:       rd = {4'd0, pan_q};
						IDX_COLOR_SEL: rd = color_sel_q;
						default:       rd = 8'd0;
					endcase
				end
			end
			REQ_TRANSLATE: begin
				if (cfg.remap_low4) begin
					if (mode_ctrl_q[7])
						dac_v = {color_sel_q[3:0], dac_v[3:0]};
				end else if (cfg.video_mode != VMODE_256) begin
					if (mode_ctrl_q[7])
						dac_v = {2'b00, color_sel_q[1:0], dac_v[3:0]};
					dac_v[7:6] = color_sel_q[3:2];
				end
				dac = cfg.is_vga ? dac_v : {4'd0, item.pixel_attr};
			end
			default: ;
		endcase
	end

	assign res.read_data = rd;
	assign res.dac_index = dac;
	assign res.pel_shift = shift_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_phase_q <= 1'b0;
			reg_index_q  <= 5'd0;
			pal_access_q <= 1'b0;
			mode_ctrl_q  <= 8'd0;
			border_q     <= 8'd0;
			plane_en_q   <= 8'd0;
			pan_q        <= 4'd0;
			color_sel_q  <= 8'd0;
			shift_q      <= 4'd0;
			for (int i = 0; i < PALETTE_ENTRIES; i++)
				palette_q[i] <= 6'd0;
		end else if (step) begin
			data_phase_q <= data_phase_d;
			reg_index_q  <= reg_index_d;
			pal_access_q <= pal_access_d;
			mode_ctrl_q  <= mode_ctrl_d;
			border_q     <= border_d;
			plane_en_q   <= plane_en_d;
			pan_q        <= pan_d;
			color_sel_q  <= color_sel_d;
			shift_q      <= shift_d;
			if (pal_we)
				palette_q[reg_index_q[PAL_AW-1:0]] <= item.write_value[5:0];
		end
	end

endmodule
`default_nettype wire
